@@ src/rlp_pkg.sv @@
// Shared types and constants for the RLP stream encoder.
`timescale 1ns / 1ps

package rlp_pkg;

   localparam int unsigned LenWidth   = 64;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned FrameBytes = 9;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned WordBytes  = 8;

   localparam logic [ByteWidth-1:0] StrOffset  = 8'h80;
   localparam logic [ByteWidth-1:0] ListOffset = 8'hC0;
   localparam logic [ByteWidth-1:0] LongBase   = 8'd55;
   localparam logic [ByteWidth-1:0] SingleHdr  = 8'h81;
   localparam logic [LenWidth-1:0]  ShortLimit = 64'd56;

   typedef enum logic [CmdWidth-1:0] {
      CMD_STRING = 2'd0,
      CMD_LIST   = 2'd1,
      CMD_UINT   = 2'd2,
      CMD_DATA   = 2'd3
   } cmd_type;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [CountWidth-1:0] count_type;

   typedef struct packed {
      logic [CmdWidth-1:0]   command;
      logic [LenWidth-1:0]   item_length;
      logic [ValueWidth-1:0] uint_value;
      byte_type              data_byte;
   } req_item_type;

   typedef struct packed {
      byte_type [FrameBytes-1:0] bytes;
      count_type                 count;
   } frame_type;

endpackage

@@ src/rlp_stream_if.sv @@
// Handshake channels for request items and encoded byte results.
`timescale 1ns / 1ps

interface rlp_req_if import rlp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CmdWidth-1:0]   command;
   logic [LenWidth-1:0]   item_length;
   logic [ValueWidth-1:0] uint_value;
   logic [ByteWidth-1:0]  data_byte;

   modport source (output valid, command, item_length, uint_value, data_byte, input ready);
   modport sink   (input valid, command, item_length, uint_value, data_byte, output ready);
endinterface

interface rlp_rsp_if import rlp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

@@ src/rlp_stream_encoder.sv @@
// Top level of the RLP stream encoder: input register, frame builder, serializer.
// An item is registered in the input stage, then its frame is loaded into the
// serializer register, whose first byte appears on rsp. Throughput: one item per
// cycle for one-byte items while rsp is ready; an item giving n bytes holds the input
// while its frame shifts out (n up to 9). A one-byte string gives no byte.
// Reset (synchronous, active high) empties both stages and clears the deferred header.
`timescale 1ns / 1ps

module rlp_stream_encoder import rlp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rlp_req_if.sink   req_chan,
   rlp_rsp_if.source rsp_chan
);

   req_item_type item_ff, item_in;
   logic         stage_valid_ff, stage_valid_in;
   logic         pending_ff, pending_in;
   logic         pending_next;
   logic         load_ok;
   logic         stage_take;
   logic         req_take;
   frame_type    frame;

   assign stage_take     = stage_valid_ff && load_ok;
   assign req_chan.ready = !stage_valid_ff || load_ok;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Capture the incoming item; hold it until the serializer takes its frame
   always_comb begin
      item_in        = req_take ? {req_chan.command, req_chan.item_length,
                                   req_chan.uint_value, req_chan.data_byte} : item_ff;
      stage_valid_in = req_take ? 1'b1 : (stage_take ? 1'b0 : stage_valid_ff);
      pending_in     = stage_take ? pending_next : pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pending_ff     <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pending_ff     <= pending_in;
      end
      item_ff <= item_in;
   end

   rlp_frame_build u_build (
      .item         (item_ff),
      .pending      (pending_ff),
      .frame        (frame),
      .pending_next (pending_next)
   );

   rlp_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .frame    (frame),
      .load     (stage_take),
      .load_ok  (load_ok),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_pending_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(pending_ff)) |-> $past(stage_take))
      else $error("deferred header set without a taken item");
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_chan.ready)
      else $error("empty stage refuses an item");
   a_held: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !load_ok) |=> (stage_valid_ff && $stable(item_ff)))
      else $error("stalled item lost");
`endif

endmodule

@@ src/rlp_frame_build.sv @@
// Builds the full byte frame (header plus big-endian bytes) for one item.
`timescale 1ns / 1ps

module rlp_frame_build import rlp_pkg::*; (
   input  req_item_type item,
   input  logic         pending,
   output frame_type    frame,
   output logic         pending_next
);

   logic [ValueWidth-1:0] word;
   count_type             nbytes;
   logic [6:0]            shamt;
   logic [ValueWidth-1:0] aligned;
   byte_type              offset;
   byte_type              long_hdr;

   // Pick the value whose bytes may follow the header
   assign word = (item.command == CMD_UINT) ? item.uint_value : item.item_length;

   // Count significant bytes of the word
   always_comb begin
      nbytes = '0;
      for (int i = 0; i < WordBytes; i++) begin
         if (word[i*ByteWidth +: ByteWidth] != '0) begin
            nbytes = count_type'(i + 1);
         end
      end
   end

   // Left-align the significant bytes so they read out from the top
   assign shamt   = 7'({4'(WordBytes) - nbytes, 3'b000});
   assign aligned = word << shamt;

   assign offset   = (item.command == CMD_LIST) ? ListOffset : StrOffset;
   assign long_hdr = (item.command == CMD_UINT) ? (StrOffset + {4'b0, nbytes})
                                                : (offset + LongBase + {4'b0, nbytes});

   // Assemble the frame for the command
   always_comb begin
      frame.bytes = '0;
      frame.count = '0;
      for (int i = 0; i < WordBytes; i++) begin
         frame.bytes[i+1] = aligned[ValueWidth-1-i*ByteWidth -: ByteWidth];
      end
      case (item.command)
         CMD_DATA: begin
            if (pending && item.data_byte >= StrOffset) begin
               frame.bytes[0] = SingleHdr;
               frame.bytes[1] = item.data_byte;
               frame.count    = count_type'(2);
            end else begin
               frame.bytes[0] = item.data_byte;
               frame.count    = count_type'(1);
            end
         end
         CMD_STRING, CMD_LIST: begin
            if (item.command == CMD_STRING && item.item_length == 64'd1) begin
               frame.count = '0;
            end else if (item.item_length < ShortLimit) begin
               frame.bytes[0] = offset + item.item_length[ByteWidth-1:0];
               frame.count    = count_type'(1);
            end else begin
               frame.bytes[0] = long_hdr;
               frame.count    = nbytes + count_type'(1);
            end
         end
         CMD_UINT: begin
            if (item.uint_value == '0) begin
               frame.bytes[0] = StrOffset;
               frame.count    = count_type'(1);
            end else if (item.uint_value < 64'(StrOffset)) begin
               frame.bytes[0] = item.uint_value[ByteWidth-1:0];
               frame.count    = count_type'(1);
            end else begin
               frame.bytes[0] = long_hdr;
               frame.count    = nbytes + count_type'(1);
            end
         end
         default: begin
            frame.count = '0;
         end
      endcase
   end

   // Defer the header of a one-byte string; any other item clears it
   assign pending_next = (item.command == CMD_STRING) && (item.item_length == 64'd1);

endmodule

@@ src/rlp_serializer.sv @@
// Shifts a loaded frame out on the result channel, one byte per cycle while it is ready.
`timescale 1ns / 1ps

module rlp_serializer import rlp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  frame_type frame,
   input  logic      load,
   output logic      load_ok,
   rlp_rsp_if.source rsp_chan
);

   byte_type [FrameBytes-1:0] bytes_ff, bytes_in;
   count_type                 rem_ff, rem_in;
   logic                      emit;

   assign emit    = (rem_ff != '0) && rsp_chan.ready;
   assign load_ok = (rem_ff == '0) || ((rem_ff == count_type'(1)) && rsp_chan.ready);

   // Load a new frame, or advance by one byte on each taken byte
   always_comb begin
      bytes_in = bytes_ff;
      rem_in   = rem_ff;
      if (load) begin
         bytes_in = frame.bytes;
         rem_in   = frame.count;
      end else if (emit) begin
         for (int i = 0; i < FrameBytes - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         rem_in = rem_ff - count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      bytes_ff <= bytes_in;
   end

   assign rsp_chan.valid       = (rem_ff != '0);
   assign rsp_chan.out_byte    = bytes_ff[0];
   assign rsp_chan.last_of_run = (rem_ff == count_type'(1));

`ifndef SYNTHESIS
   a_load_fits: assert property (@(posedge clock) disable iff (reset)
      load |-> (frame.count <= count_type'(FrameBytes)))
      else $error("frame longer than buffer");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= count_type'(FrameBytes))
      else $error("remaining count out of range");
   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ok)
      else $error("frame loaded over unsent bytes");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == count_type'(1) && rsp_chan.ready && !load) |=> (rem_ff == '0))
      else $error("last byte not retired");
`endif

endmodule

@@ tb/rlp_stream_checker.sv @@
// Checker for the RLP stream encoder: watches both channels, predicts bytes, compares them.
`timescale 1ns / 1ps

module rlp_stream_checker import rlp_pkg::*; (
   input  logic clock,
   input  logic reset,
   rlp_req_if   req_mon,
   rlp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   localparam int MaxReports = 10;

   typedef struct packed {
      byte_type value;
      logic     last;
   } coded_byte_type;

   // Bytes still owed by the encoder, oldest first
   coded_byte_type expected_bytes[$];
   // Bytes caused by the item being predicted
   byte_type       run_bytes[$];
   // Set while a one-byte string waits for its payload byte
   logic           single_deferred;

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      single_deferred = 1'b0;
   end

   // Add one byte at the tail of the current item's run
   function automatic void append_byte(input byte_type b);
      run_bytes.insert(run_bytes.size(), b);
   endfunction

   function automatic int significant_bytes(input logic [63:0] v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v = v >> 8;
      end
      return n;
   endfunction

   // Append v as n big-endian bytes with no leading zeros
   function automatic void add_be(input logic [63:0] v);
      int n;
      n = significant_bytes(v);
      for (int i = n - 1; i >= 0; i--) begin
         append_byte(v[8*i +: 8]);
      end
   endfunction

   // Short form below 56, else length-of-length byte plus the length itself
   function automatic void add_header(input logic [63:0] len, input byte_type offset);
      if (len < ShortLimit) begin
         append_byte(offset + len[7:0]);
      end else begin
         append_byte(offset + LongBase + byte_type'(significant_bytes(len)));
         add_be(len);
      end
   endfunction

   always @(posedge clock) begin
      coded_byte_type got;
      coded_byte_type want;
      if (reset) begin
         single_deferred = 1'b0;
         expected_bytes.delete();
      end else begin
         // Predict the bytes of each accepted item
         if (req_mon.valid && req_mon.ready) begin
            run_bytes.delete();
            case (cmd_type'(req_mon.command))
               CMD_DATA: begin
                  if (single_deferred && req_mon.data_byte >= StrOffset) begin
                     append_byte(SingleHdr);
                  end
                  append_byte(req_mon.data_byte);
                  single_deferred = 1'b0;
               end
               CMD_STRING: begin
                  single_deferred = (req_mon.item_length == 64'd1);
                  if (!single_deferred) begin
                     add_header(req_mon.item_length, StrOffset);
                  end
               end
               CMD_LIST: begin
                  single_deferred = 1'b0;
                  add_header(req_mon.item_length, ListOffset);
               end
               CMD_UINT: begin
                  single_deferred = 1'b0;
                  if (req_mon.uint_value == 0) begin
                     append_byte(StrOffset);
                  end else if (req_mon.uint_value < 64'(StrOffset)) begin
                     append_byte(req_mon.uint_value[7:0]);
                  end else begin
                     append_byte(StrOffset +
                                 byte_type'(significant_bytes(req_mon.uint_value)));
                     add_be(req_mon.uint_value);
                  end
               end
               default: ;
            endcase
            foreach (run_bytes[i]) begin
               expected_bytes.insert(expected_bytes.size(),
                                     coded_byte_type'{value: run_bytes[i],
                                                      last: (i == run_bytes.size() - 1)});
            end
         end

         // Compare each accepted byte with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = coded_byte_type'{value: rsp_mon.out_byte, last: rsp_mon.last_of_run};
            if (expected_bytes.size() == 0) begin
               if (fail_count < MaxReports) begin
                  $display("%0t: unexpected byte %02h last %0b", $time, got.value, got.last);
               end
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (got !== want) begin
                  if (fail_count < MaxReports) begin
                     $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                              $time, want.value, want.last, got.value, got.last);
                  end
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_bytes.size();
   end

endmodule

@@ tb/rlp_stream_encoder_tb.sv @@
// Testbench top for the RLP stream encoder: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module rlp_stream_encoder_tb import rlp_pkg::*; ();

   localparam int HalfPeriod  = 5;
   localparam int ResetCycles = 7;
   localparam int QuietLimit  = 2000;
   localparam int LongHold    = 400;
   localparam int DrainCycles = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   items_sent;
   int   quiet_cycles;
   logic idle_on;
   logic stall_on;
   logic hold_rsp_request;

   rlp_req_if req_bus ();
   rlp_rsp_if rsp_bus ();

   rlp_stream_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   rlp_stream_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #HalfPeriod clock = ~clock;

   // End the run when neither channel moves for too long
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("FAIL rlp_stream_encoder");
         $finish;
      end
   end

   // Drive result ready: random stall bursts, one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp_request) begin
            rsp_bus.ready <= 1'b0;
            hold_rsp_request = 1'b0;
            repeat (LongHold) @(negedge clock);
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic logic [63:0] noise64();
      return {$urandom, $urandom};
   endfunction

   // Random value with a random count of significant bytes, zero to eight
   function automatic logic [63:0] rand_wide();
      logic [63:0] v;
      int          nb;
      v  = noise64();
      nb = $urandom_range(0, 8);
      if (nb < 8) begin
         v = v & ((64'd1 << (8 * nb)) - 64'd1);
      end
      return v;
   endfunction

   // Offer one item from a falling edge and hold it until accepted
   task automatic send_item(input cmd_type cmd, input logic [63:0] len,
                            input logic [63:0] val, input byte_type db);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.item_length <= len;
      req_bus.uint_value  <= val;
      req_bus.data_byte   <= db;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed RLP fragments with random content, some broken ones
   task automatic send_random_sequence();
      int          kind;
      int          count;
      logic [63:0] len;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         // one-byte string followed by its payload byte
         send_item(CMD_STRING, 64'd1, noise64(), byte_type'($urandom));
         send_item(CMD_DATA, noise64(), noise64(), byte_type'($urandom));
      end else if (kind < 45) begin
         // short string around the short/long boundary with a few payload bytes
         len   = 64'($urandom_range(0, 70));
         count = (len > 6) ? 6 : int'(len);
         send_item(CMD_STRING, len, noise64(), byte_type'($urandom));
         repeat (count) send_item(CMD_DATA, noise64(), noise64(), byte_type'($urandom));
      end else if (kind < 60) begin
         len = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 70)) : rand_wide();
         send_item(CMD_LIST, len, noise64(), byte_type'($urandom));
      end else if (kind < 80) begin
         send_item(CMD_UINT, noise64(), rand_wide(), byte_type'($urandom));
      end else if (kind < 90) begin
         send_item(CMD_DATA, noise64(), noise64(), byte_type'($urandom));
      end else if (kind < 95) begin
         // one-byte string abandoned by a new header or integer
         send_item(CMD_STRING, 64'd1, noise64(), byte_type'($urandom));
         send_item(cmd_type'($urandom_range(CMD_STRING, CMD_UINT)), rand_wide(),
                   rand_wide(), byte_type'($urandom));
      end else begin
         send_item(CMD_STRING, rand_wide(), noise64(), byte_type'($urandom));
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_STRING;
      req_bus.item_length = '0;
      req_bus.uint_value  = '0;
      req_bus.data_byte   = '0;
      items_sent          = 0;
      idle_on             = 1'b1;
      stall_on            = 1'b1;
      hold_rsp_request    = 1'b0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;

      // String headers at the short/long boundary and the widest length
      send_item(CMD_STRING, 64'd0, 64'd0, 8'h00);
      send_item(CMD_STRING, 64'd55, 64'd0, 8'h00);
      send_item(CMD_STRING, 64'd56, 64'd0, 8'h00);
      send_item(CMD_STRING, '1, 64'd0, 8'h00);
      // Deferred single byte: bare below 0x80, prefixed otherwise
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_DATA, 64'd0, 64'd0, 8'h00);
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_DATA, 64'd0, 64'd0, 8'h7F);
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_DATA, 64'd0, 64'd0, 8'h80);
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_DATA, 64'd0, 64'd0, 8'hFF);
      // Deferred header dropped by a list and by an integer
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_LIST, 64'd3, 64'd0, 8'h00);
      send_item(CMD_STRING, 64'd1, 64'd0, 8'h00);
      send_item(CMD_UINT, 64'd0, 64'h400, 8'h00);
      // List headers
      send_item(CMD_LIST, 64'd0, 64'd0, 8'h00);
      send_item(CMD_LIST, 64'd55, 64'd0, 8'h00);
      send_item(CMD_LIST, 64'd56, 64'd0, 8'h00);
      send_item(CMD_LIST, '1, 64'd0, 8'h00);
      // Integers: zero, bare range edge, first prefixed value, widest
      send_item(CMD_UINT, 64'd0, 64'd0, 8'h00);
      send_item(CMD_UINT, 64'd0, 64'h7F, 8'h00);
      send_item(CMD_UINT, 64'd0, 64'h80, 8'h00);
      send_item(CMD_UINT, 64'd0, '1, 8'h00);
      // Payload bytes with nothing pending
      send_item(CMD_DATA, 64'd0, 64'd0, 8'h00);
      send_item(CMD_DATA, '1, '1, 8'hFF);

      while (items_sent < 140) send_random_sequence();

      // Hold the result side off while items keep coming, so the input backs up
      idle_on          = 1'b0;
      hold_rsp_request = 1'b1;
      repeat (40) send_random_sequence();
      idle_on = 1'b1;

      while (items_sent < 230) send_random_sequence();

      // Pause the sender until every predicted byte has come out
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);

      while (items_sent < 320) send_random_sequence();

      // Run the last stretch with no idling on either side
      idle_on  = 1'b0;
      stall_on = 1'b0;
      while (items_sent < 380) send_random_sequence();
      req_bus.valid <= 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS rlp_stream_encoder");
      end else begin
         $display("FAIL rlp_stream_encoder");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/rlp_pkg.sv
src/rlp_stream_if.sv
src/rlp_frame_build.sv
src/rlp_serializer.sv
src/rlp_stream_encoder.sv
tb/rlp_stream_checker.sv
tb/rlp_stream_encoder_tb.sv
